// ===== hw/rtl/i2crrm_pkg.sv =====
// i2crrm_pkg: types, phase map constants and phase decode functions for the
// i2c register read master. No dependencies.

package i2crrm_pkg;

    localparam logic [6:0] ADDR_RESET = 7'd72;
    localparam logic [7:0] BIT_MSB    = 8'h80;

    // phase map of one transaction
    localparam logic [7:0] PH_START_SCL = 8'd1;
    localparam logic [7:0] PH_ADDR_W    = 8'd2;
    localparam logic [7:0] PH_PTR       = 8'd29;
    localparam logic [7:0] PH_STOP_SCL  = 8'd56;
    localparam logic [7:0] PH_STOP_SDA  = 8'd57;
    localparam logic [7:0] PH_RSTART    = 8'd58;
    localparam logic [7:0] PH_RSTART_SCL = 8'd59;
    localparam logic [7:0] PH_ADDR_R    = 8'd60;
    localparam logic [7:0] PH_RD_HI     = 8'd87;
    localparam logic [7:0] PH_RD_LO     = 8'd107;
    localparam logic [7:0] PH_END_SCL   = 8'd127;
    localparam logic [7:0] PH_LAST      = 8'd128;

    localparam int unsigned WR_BITS = 8;

    typedef struct packed {
        logic sda_en;
        logic sda_val;
        logic scl_en;
        logic scl_val;
        logic shift;
    } pin_act_t;

    // one phase of a written byte: 8 x (sda, scl up, scl down), then ack slot
    function automatic pin_act_t wr_step(input logic [4:0] q, input logic [7:0] data);
        pin_act_t    act;
        logic [2:0]  bit_idx;
        logic [4:0]  base;
        logic [4:0]  sub;
        act     = '0;
        bit_idx = '0;
        for (int i = 1; i < WR_BITS; i++)
        begin
            if (q >= 5'(3 * i))
                bit_idx = 3'(i);
        end
        base = 5'(3 * bit_idx);
        sub  = q - base;
        if (q < 5'(3 * WR_BITS))
        begin
            if (sub == 5'd0)
            begin
                act.sda_en  = 1'b1;
                act.sda_val = |((data << bit_idx) & BIT_MSB);
            end
            else
            begin
                act.scl_en  = 1'b1;
                act.scl_val = (sub == 5'd1);
            end
        end
        else if (q == 5'(3 * WR_BITS))
        begin
            act.sda_en  = 1'b1;
            act.sda_val = 1'b1;
        end
        else
        begin
            act.scl_en  = 1'b1;
            act.scl_val = (q == 5'(3 * WR_BITS + 1));
        end
        return act;
    endfunction

    // one phase of a read byte: release, 8 x (scl up + sample, scl down), master ack
    function automatic pin_act_t rd_step(input logic [4:0] r);
        pin_act_t act;
        act = '0;
        if (r == 5'd0)
        begin
            act.sda_en  = 1'b1;
            act.sda_val = 1'b1;
        end
        else if (r <= 5'd16)
        begin
            act.scl_en  = 1'b1;
            act.scl_val = r[0];
            act.shift   = r[0];
        end
        else if (r == 5'd17)
        begin
            act.sda_en  = 1'b1;
            act.sda_val = 1'b0;
        end
        else
        begin
            act.scl_en  = 1'b1;
            act.scl_val = (r == 5'd18);
        end
        return act;
    endfunction

endpackage

// ===== hw/rtl/i2c_register_read_master_top.sv =====
// i2c_register_read_master_top: bit-level i2c master reading a 16-bit register.
// Depends on i2crrm_pkg for the phase map and phase decode functions.
//
// Usage: the input channel (in_valid/in_stall) carries cmd, register_pointer
// and sda_in. A beat with cmd 1 arms a transaction and latches the pointer
// (ignored while busy); each later beat with cmd 0 drives one pin phase, 129
// phases in all: start, write address+W, write pointer, stop, start, address+R,
// read two bytes with master ack, stop. sda_in is sampled on read phases only.
// Every accepted beat yields exactly one result beat on the output channel
// (out_valid/out_stall) with the pin levels, busy_res, and done_res which
// pulses with read_data on the final stop beat (read_data is 0 otherwise).
// The result beat is registered in the single next-state/result stage; one
// beat per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds and in_stall rises so
// no further beat is taken until the result is delivered.
// cfg_we/cfg_wdata write the 7-bit device address; write only while idle.
// Reset puts the bus lines released, the master idle, address 72, and empties
// the result register.

module i2c_register_read_master_top
    import i2crrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  register_pointer,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        done_res,
    output logic [15:0] read_data
);

    logic [6:0]  addr_reg;
    logic [7:0]  phase_reg, phase_next;
    logic [15:0] shift_reg, shift_next;
    logic [7:0]  ptr_reg, ptr_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        active_reg, active_next;
    logic        done_next;

    logic        out_valid_reg;
    logic        scl_out_reg, sda_out_reg, busy_reg, done_reg;
    logic [15:0] data_reg;

    logic        accept;
    logic [7:0]  addr_w, addr_r;
    logic [7:0]  off_w1, off_w2, off_w3, off_r1, off_r2;
    pin_act_t    act;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign addr_w = {addr_reg, 1'b0};
    assign addr_r = {addr_reg, 1'b1};
    assign off_w1 = phase_reg - PH_ADDR_W;
    assign off_w2 = phase_reg - PH_PTR;
    assign off_w3 = phase_reg - PH_ADDR_R;
    assign off_r1 = phase_reg - PH_RD_HI;
    assign off_r2 = phase_reg - PH_RD_LO;

    // pin action of the current phase
    always_comb
    begin
        act = '0;
        if (phase_reg == 8'd0)
        begin
            act.sda_en = 1'b1;
        end
        else if (phase_reg == PH_START_SCL)
        begin
            act.scl_en = 1'b1;
        end
        else if (phase_reg < PH_PTR)
        begin
            act = wr_step(off_w1[4:0], addr_w);
        end
        else if (phase_reg < PH_STOP_SCL)
        begin
            act = wr_step(off_w2[4:0], ptr_reg);
        end
        else if (phase_reg == PH_STOP_SCL)
        begin
            act.scl_en  = 1'b1;
            act.scl_val = 1'b1;
        end
        else if (phase_reg == PH_STOP_SDA)
        begin
            act.sda_en  = 1'b1;
            act.sda_val = 1'b1;
        end
        else if (phase_reg == PH_RSTART)
        begin
            act.sda_en = 1'b1;
        end
        else if (phase_reg == PH_RSTART_SCL)
        begin
            act.scl_en = 1'b1;
        end
        else if (phase_reg < PH_RD_HI)
        begin
            act = wr_step(off_w3[4:0], addr_r);
        end
        else if (phase_reg < PH_RD_LO)
        begin
            act = rd_step(off_r1[4:0]);
        end
        else if (phase_reg < PH_END_SCL)
        begin
            act = rd_step(off_r2[4:0]);
        end
        else if (phase_reg == PH_END_SCL)
        begin
            act.scl_en  = 1'b1;
            act.scl_val = 1'b1;
        end
        else
        begin
            act.sda_en  = 1'b1;
            act.sda_val = 1'b1;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        ptr_next    = ptr_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (cmd)
        begin
            if (!active_reg)
            begin
                active_next = 1'b1;
                ptr_next    = register_pointer;
                phase_next  = '0;
                shift_next  = '0;
            end
        end
        else if (active_reg)
        begin
            if (act.sda_en)
                sda_next = act.sda_val;
            if (act.scl_en)
                scl_next = act.scl_val;
            if (act.shift)
                shift_next = {shift_reg[14:0], sda_in};
            if (phase_reg >= PH_LAST)
            begin
                done_next   = 1'b1;
                active_next = 1'b0;
                phase_next  = '0;
            end
            else
            begin
                phase_next = phase_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= ADDR_RESET;
            phase_reg     <= '0;
            shift_reg     <= '0;
            ptr_reg       <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                addr_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                ptr_reg       <= ptr_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_out_reg <= scl_next;
            sda_out_reg <= sda_next;
            busy_reg    <= active_next;
            done_reg    <= done_next;
            data_reg    <= done_next ? shift_next : 16'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = scl_out_reg;
    assign sda_out   = sda_out_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign read_data = data_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !busy_reg)
        else $error("done beat reports busy");

    a_data_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> data_reg == 16'd0)
        else $error("read data without done");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_LAST)
        else $error("phase counter out of range");

    a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> phase_reg == 8'd0)
        else $error("phase counter nonzero while idle");

endmodule

// ===== tb/i2c_register_read_master_top_tb.sv =====
// i2c_register_read_master_top_tb: self-checking bench for the i2c register read master.
// Drives command/tick beats, predicts pin levels and the read word per beat, checks every result.
// Depends on i2crrm_pkg (phase map constants) and i2c_register_read_master_top.

module i2c_register_read_master_top_tb;
    import i2crrm_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   OPENING_ROWS = 11;

    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [15:0] data;
    } pin_result_t;

    typedef struct packed {
        logic        c;
        logic [7:0]  ptr;
        logic        sda;
        logic [7:0]  reps;
        logic        pinned;
        pin_result_t want;
    } opening_row_t;

    // pinned results apply to the last beat of a row
    localparam opening_row_t OPENING [OPENING_ROWS] = '{
        '{CMD_TICK,  8'h00, 1'b0, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000}},
        '{CMD_START, 8'hFF, 1'b0, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000}},
        '{CMD_START, 8'h00, 1'b1, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'h00, 1'b1, 8'd1,   1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'hFF, 1'b1, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'h00, 1'b1, 8'd126, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'h00, 1'b1, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF}},
        '{CMD_TICK,  8'hFF, 1'b1, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000}},
        '{CMD_START, 8'h00, 1'b0, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'hFF, 1'b0, 8'd128, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
        '{CMD_TICK,  8'h00, 1'b0, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 16'h0000}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = CMD_TICK;
    logic [7:0]  register_pointer = 8'h00;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;

    // bus master state as predicted
    logic [7:0]  cur_phase = 8'd0;
    logic [15:0] rd_word = 16'h0000;
    logic [7:0]  ptr_latch = 8'h00;
    logic        scl_lvl = 1'b1;
    logic        sda_lvl = 1'b1;
    logic        busy_lvl = 1'b0;
    logic [6:0]  dev_addr = ADDR_RESET;

    pin_result_t result_q [$];
    int          errors = 0;
    int          beats_sent = 0;
    int          reads_completed = 0;
    logic        calm = 1'b0;

    i2c_register_read_master_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .register_pointer (register_pointer),
        .sda_in           (sda_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scl_out          (scl_out),
        .sda_out          (sda_out),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_data        (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one phase of a written byte: per bit set sda, scl up, scl down; then the ack slot
    function automatic void put_write_phase(input int unsigned k, input logic [7:0] b);
        if (k < 24)
        begin
            if (k % 3 == 0)
                sda_lvl = b[7 - k / 3];
            else
                scl_lvl = (k % 3 == 1);
        end
        else if (k == 24)
            sda_lvl = 1'b1;
        else
            scl_lvl = (k == 25);
    endfunction

    // one phase of a read byte: release, sample on each scl rise, then master ack
    function automatic void put_read_phase(input int unsigned k, input logic s);
        if (k == 0)
            sda_lvl = 1'b1;
        else if (k <= 16)
        begin
            if (k % 2 == 1)
            begin
                rd_word = {rd_word[14:0], s};
                scl_lvl = 1'b1;
            end
            else
                scl_lvl = 1'b0;
        end
        else if (k == 17)
            sda_lvl = 1'b0;
        else
            scl_lvl = (k == 18);
    endfunction

    function automatic pin_result_t bus_step(input logic c, input logic [7:0] p, input logic s);
        pin_result_t r;
        logic [7:0]  addr_wr;
        logic        fin;
        int unsigned k;
        addr_wr = {dev_addr, 1'b0};
        fin = 1'b0;
        k = cur_phase;
        if (c == CMD_START)
        begin
            if (!busy_lvl)
            begin
                busy_lvl = 1'b1;
                ptr_latch = p;
                cur_phase = 8'd0;
                rd_word = 16'h0000;
            end
        end
        else if (busy_lvl)
        begin
            if (k < PH_ADDR_W)
            begin
                if (k == 0)
                    sda_lvl = 1'b0;
                else
                    scl_lvl = 1'b0;
            end
            else if (k < PH_PTR)
                put_write_phase(k - PH_ADDR_W, addr_wr);
            else if (k < PH_STOP_SCL)
                put_write_phase(k - PH_PTR, ptr_latch);
            else if (k == PH_STOP_SCL)
                scl_lvl = 1'b1;
            else if (k == PH_STOP_SDA)
                sda_lvl = 1'b1;
            else if (k == PH_RSTART)
                sda_lvl = 1'b0;
            else if (k == PH_RSTART_SCL)
                scl_lvl = 1'b0;
            else if (k < PH_RD_HI)
                put_write_phase(k - PH_ADDR_R, addr_wr | 8'h01);
            else if (k < PH_RD_LO)
                put_read_phase(k - PH_RD_HI, s);
            else if (k < PH_END_SCL)
                put_read_phase(k - PH_RD_LO, s);
            else if (k == PH_END_SCL)
                scl_lvl = 1'b1;
            else
                sda_lvl = 1'b1;
            if (k >= PH_LAST)
            begin
                fin = 1'b1;
                busy_lvl = 1'b0;
                cur_phase = 8'd0;
            end
            else
                cur_phase = 8'(k + 1);
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = busy_lvl;
        r.done = fin;
        r.data = fin ? rd_word : 16'h0000;
        return r;
    endfunction

    task automatic send_beat(input logic c, input logic [7:0] p, input logic s,
                             input logic pinned, input pin_result_t pinned_val);
        pin_result_t pred;
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        register_pointer <= p;
        sda_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = bus_step(c, p, s);
        result_q.push_back(pinned ? pinned_val : pred);
        beats_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        // the result is registered, so the spare cycles below are plenty
        repeat (3) @(posedge clk);
    endtask

    task automatic write_address(input logic [6:0] a);
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we <= 1'b0;
        dev_addr = a;
    endtask

    // mostly whole transactions with random read bits, plus idle ticks and stray starts
    task automatic run_traffic(input int target);
        int count;
        count = 0;
        while (count < target || busy_lvl)
        begin
            if (!busy_lvl)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_beat(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                    count++;
                end
                send_beat(CMD_START, 8'($urandom), 1'($urandom), 1'b0, '0);
            end
            else if ($urandom_range(99) < 3)
                send_beat(CMD_START, 8'($urandom), 1'($urandom), 1'b0, '0);
            else
                send_beat(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
            count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin : check_results
        pin_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (scl_out !== want.scl)
                begin
                    $error("scl_out: expected %0d, got %0d", want.scl, scl_out);
                    errors++;
                end
                if (sda_out !== want.sda)
                begin
                    $error("sda_out: expected %0d, got %0d", want.sda, sda_out);
                    errors++;
                end
                if (busy_res !== want.busy)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
                    errors++;
                end
                if (done_res !== want.done)
                begin
                    $error("done_res: expected %0d, got %0d", want.done, done_res);
                    errors++;
                end
                if (read_data !== want.data)
                begin
                    $error("read_data: expected 0x%04h, got 0x%04h", want.data, read_data);
                    errors++;
                end
                if (want.done)
                    reads_completed++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [6:0] addr_plan [3];
        addr_plan = '{7'd127, 7'd0, 7'($urandom)};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < OPENING_ROWS; i++)
        begin
            for (int j = 0; j < OPENING[i].reps; j++)
                send_beat(OPENING[i].c, OPENING[i].ptr, OPENING[i].sda,
                          OPENING[i].pinned && (j == OPENING[i].reps - 1), OPENING[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            write_address(addr_plan[ph]);
            // address 0 phase runs with no gaps or stalls on either side
            calm = (ph == 1);
            run_traffic(130);
        end
        calm = 1'b0;
        drain();

        $display("sent %0d beats across address settings 72, 127, 0 and one random one",
                 beats_sent);
        $display("%0d register reads completed with random read bits and stray starts",
                 reads_completed);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
